### rtl/fdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_pkg: shared types and constants
// Digit type, step count of the digit search and the small residue table.
// ----------------------------------------------------------------------------
package fdd_pkg;

  typedef logic [3:0] digit_t;

  // additions of the remainder that decide one decimal digit
  localparam int unsigned DIGIT_STEPS = 10;

  // 10 mod m for a denominator of at most ten
  function automatic digit_t ten_mod(input logic [3:0] m);
    digit_t r;
    unique case (m)
      4'd3:    r = 4'd1;
      4'd4:    r = 4'd2;
      4'd6:    r = 4'd4;
      4'd7:    r = 4'd3;
      4'd8:    r = 4'd2;
      4'd9:    r = 4'd1;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/fdd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_front: input stage
// Takes an item, flags operands that cannot give a digit and hands it on.
// ----------------------------------------------------------------------------
module fdd_front #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_numerator,
  input  logic [WIDTH-1:0] in_denominator,
  input  logic [WIDTH-1:0] in_position,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [3*WIDTH:0] push_data
);

  logic             valid_r;
  logic             reject_r;
  logic [WIDTH-1:0] num_r;
  logic [WIDTH-1:0] den_r;
  logic [WIDTH-1:0] pos_r;
  logic             reject_nxt;
  logic             in_fire;

  assign in_ready = !valid_r || push_ready;
  assign in_fire  = in_valid && in_ready;

  assign reject_nxt = (in_denominator == '0) || (in_numerator >= in_denominator) ||
                      (in_position == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_fire) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      reject_r <= reject_nxt;
      num_r    <= in_numerator;
      den_r    <= in_denominator;
      pos_r    <= in_position;
    end
  end

  assign push_valid = valid_r;
  assign push_data  = {reject_r, num_r, den_r, pos_r};

endmodule

### rtl/fdd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_queue: two-entry queue
// Decouples the input stage from the digit engine.
// ----------------------------------------------------------------------------
module fdd_queue #(
  parameter int DW = 193
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_fire) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 2'd1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2) else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count missed a push");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && !push_fire) |=> count_r == $past(count_r) - 2'd1)
    else $error("queue count missed a pop");
`endif

endmodule

### rtl/fdd_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_mulmod: modular multiplier
// Shift-and-add x*y mod m, one multiplier bit per cycle; operands below m.
// ----------------------------------------------------------------------------
module fdd_mulmod #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] x_in,
  input  logic [WIDTH-1:0] y_in,
  input  logic [WIDTH-1:0] m_in,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  logic             busy_r;
  logic             done_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH:0]   acc_sum;
  logic [WIDTH:0]   dbl_sum;
  logic [WIDTH-1:0] acc_nxt;
  logic [WIDTH-1:0] x_nxt;

  // sums of two residues, folded back below m by one subtract
  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, x_r};
    dbl_sum = {1'b0, x_r} + {1'b0, x_r};
    acc_nxt = (acc_sum >= {1'b0, m_in}) ? WIDTH'(acc_sum - {1'b0, m_in}) : acc_sum[WIDTH-1:0];
    x_nxt   = (dbl_sum >= {1'b0, m_in}) ? WIDTH'(dbl_sum - {1'b0, m_in}) : dbl_sum[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (y_r == '0)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x_in;
      y_r   <= y_in;
    end else if (busy_r && (y_r != '0)) begin
      if (y_r[0]) begin
        acc_r <= acc_nxt;
      end
      x_r <= x_nxt;
      y_r <= y_r >> 1;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

### rtl/fdd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_back: digit engine
// Square-and-multiply for n*10^(p-1) mod d, then the ten-step digit search.
// ----------------------------------------------------------------------------
module fdd_back #(
  parameter int WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  logic [3*WIDTH:0]     pop_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fdd_pkg::digit_t      out_digit,
  output logic                 out_valid_res
);

  import fdd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW_CHECK,
    ST_POW_MUL,
    ST_POW_SHIFT,
    ST_POW_SQR,
    ST_FINAL,
    ST_DIGIT,
    ST_DONE
  } state_t;

  state_t           state_r;
  logic [WIDTH-1:0] num_r;
  logic [WIDTH-1:0] den_r;
  logic [WIDTH-1:0] e_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] b_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] sum_r;
  digit_t           wraps_r;
  logic [3:0]       k_r;
  digit_t           res_digit_r;
  logic             res_ok_r;
  logic             out_valid_r;
  digit_t           out_digit_r;
  logic             out_ok_r;
  logic             mm_start_r;
  logic             mm_start_nxt;
  logic [WIDTH-1:0] mm_x_r;
  logic [WIDTH-1:0] mm_y_r;
  logic             mm_done;
  logic [WIDTH-1:0] mm_result;

  logic             q_reject;
  logic [WIDTH-1:0] q_num;
  logic [WIDTH-1:0] q_den;
  logic [WIDTH-1:0] q_pos;
  logic [WIDTH:0]   dsum;
  logic             dwrap;
  logic [WIDTH-1:0] sum_nxt;

  assign {q_reject, q_num, q_den, q_pos} = pop_data;
  assign pop_ready = (state_r == ST_IDLE);

  // one addition of the remainder, counting the wrap past d
  always_comb begin
    dsum    = {1'b0, sum_r} + {1'b0, rem_r};
    dwrap   = (dsum >= {1'b0, den_r});
    sum_nxt = dwrap ? WIDTH'(dsum - {1'b0, den_r}) : dsum[WIDTH-1:0];
  end

  // launch a multiply for the final product, a set exponent bit or a squaring
  always_comb begin
    mm_start_nxt = ((state_r == ST_POW_CHECK) && ((e_r == '0) || e_r[0])) ||
                   ((state_r == ST_POW_SHIFT) && ((e_r >> 1) != '0));
  end

  fdd_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start_r),
    .x_in   (mm_x_r),
    .y_in   (mm_y_r),
    .m_in   (den_r),
    .done   (mm_done),
    .result (mm_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mm_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mm_start_r <= mm_start_nxt;
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            num_r <= q_num;
            den_r <= q_den;
            e_r   <= q_pos - WIDTH'(1);
            acc_r <= (q_den == WIDTH'(1)) ? '0 : WIDTH'(1);
            b_r   <= (q_den > WIDTH'(10)) ? WIDTH'(10) : WIDTH'(ten_mod(q_den[3:0]));
            if (q_reject) begin
              res_digit_r <= '0;
              res_ok_r    <= 1'b0;
              state_r     <= ST_DONE;
            end else begin
              state_r <= ST_POW_CHECK;
            end
          end
        end
        ST_POW_CHECK: begin
          if (e_r == '0) begin
            mm_x_r  <= num_r;
            mm_y_r  <= acc_r;
            state_r <= ST_FINAL;
          end else if (e_r[0]) begin
            mm_x_r  <= acc_r;
            mm_y_r  <= b_r;
            state_r <= ST_POW_MUL;
          end else begin
            state_r <= ST_POW_SHIFT;
          end
        end
        ST_POW_MUL: begin
          if (mm_done) begin
            acc_r   <= mm_result;
            state_r <= ST_POW_SHIFT;
          end
        end
        ST_POW_SHIFT: begin
          e_r <= e_r >> 1;
          // square only while exponent bits remain
          if ((e_r >> 1) != '0) begin
            mm_x_r  <= b_r;
            mm_y_r  <= b_r;
            state_r <= ST_POW_SQR;
          end else begin
            state_r <= ST_POW_CHECK;
          end
        end
        ST_POW_SQR: begin
          if (mm_done) begin
            b_r     <= mm_result;
            state_r <= ST_POW_CHECK;
          end
        end
        ST_FINAL: begin
          if (mm_done) begin
            rem_r   <= mm_result;
            sum_r   <= '0;
            wraps_r <= '0;
            k_r     <= '0;
            state_r <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          sum_r <= sum_nxt;
          k_r   <= k_r + 4'd1;
          if (dwrap) begin
            wraps_r <= wraps_r + 4'd1;
          end
          if (k_r == 4'(DIGIT_STEPS - 1)) begin
            res_digit_r <= dwrap ? wraps_r + 4'd1 : wraps_r;
            res_ok_r    <= 1'b1;
            state_r     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_digit_r <= res_digit_r;
            out_ok_r    <= res_ok_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_digit     = out_digit_r;
  assign out_valid_res = out_ok_r;

`ifndef ASSERT_OFF
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_digit_r == 4'd0)
    else $error("rejected item with nonzero digit");
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_digit_r <= 4'd9)
    else $error("digit above nine");
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT) |-> (rem_r < den_r) && (sum_r < den_r))
    else $error("residue not below denominator");
`endif

endmodule

### rtl/fraction_decimal_digit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_decimal_digit: decimal digit of a proper fraction
// Returns digit p after the point of n/d, with a flag for rejected operands.
// ----------------------------------------------------------------------------
// An item of numerator n, denominator d and one-based position p yields one
// result: the p-th decimal digit of n/d and valid_res = 1, or digit 0 and
// valid_res = 0 when d is zero, n is not below d or p is zero. The engine
// handles one item at a time; a queue of two in front of it and an output
// register behind it let both sides keep moving. Each modular multiply runs
// bit by bit through its multiplier, whose bit length is at most WIDTH, in
// the one shared shift-and-add multiplier. For every bit of p-1 the engine
// squares once and, when the bit is set, multiplies once more; the top bit
// skips the squaring. A final multiply by n, the digit search and the
// hand-off through the input stage, queue and output register follow.
// A rejected item skips the powering and the digit search.
// ----------------------------------------------------------------------------
module fraction_decimal_digit #(
  parameter int WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WIDTH-1:0]     in_numerator,
  input  logic [WIDTH-1:0]     in_denominator,
  input  logic [WIDTH-1:0]     in_position,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fdd_pkg::digit_t      out_digit,
  output logic                 out_valid_res
);

  import fdd_pkg::*;

  localparam int DW = 3 * WIDTH + 1;

  logic          push_valid;
  logic          push_ready;
  logic [DW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [DW-1:0] pop_data;

  fdd_front #(.WIDTH(WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_numerator   (in_numerator),
    .in_denominator (in_denominator),
    .in_position    (in_position),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  fdd_queue #(.DW(DW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fdd_back #(.WIDTH(WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit     (out_digit),
    .out_valid_res (out_valid_res)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fraction_decimal_digit
// Queries go in through a bursty driver. Each accepted query is scored against
// a 128-bit modular arithmetic predictor, and a monitor checks every result
// under a varying backpressure pattern that includes one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          DATA_W     = 64;
  localparam int          IDLE_LIMIT = 60000;
  localparam int          HOLD_LEN   = 600;
  localparam logic [63:0] ALL_ONES   = '1;

  typedef struct packed {
    logic [DATA_W-1:0] numerator;
    logic [DATA_W-1:0] denominator;
    logic [DATA_W-1:0] position;
  } fraction_query_t;

  typedef struct packed {
    fdd_pkg::digit_t digit;
    logic            ok;
  } digit_answer_t;

  typedef enum int {REJ_ZERO_DEN, REJ_BIG_NUM, REJ_ZERO_POS} reject_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_numerator = '0;
  logic [DATA_W-1:0] in_denominator = '0;
  logic [DATA_W-1:0] in_position = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  fdd_pkg::digit_t   out_digit;
  logic              out_valid_res;

  fraction_query_t queries_to_send[$];
  digit_answer_t   digits_due[$];

  int errors = 0;
  int digits_seen = 0;
  int accepted_sets = 0;
  int rejected_sets = 0;
  int long_positions = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fraction_decimal_digit #(
    .WIDTH(DATA_W)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_numerator  (in_numerator),
    .in_denominator(in_denominator),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit     (out_digit),
    .out_valid_res (out_valid_res)
  );

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] pow_mod(input logic [63:0] base, input logic [63:0] expo,
                                          input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] b;
    logic [63:0] e;
    acc = 64'd1 % m;
    b = base % m;
    e = expo;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, b, m);
      e = e >> 1;
      b = mul_mod(b, b, m);
    end
    return acc;
  endfunction

  function automatic digit_answer_t predict_digit(input fraction_query_t q);
    digit_answer_t ans;
    logic [63:0]   rem;
    logic [67:0]   scaled;
    ans = '0;
    if (q.denominator != 0 && q.numerator < q.denominator && q.position != 0) begin
      rem = mul_mod(q.numerator, pow_mod(64'd10, q.position - 64'd1, q.denominator),
                    q.denominator);
      // rem < d, so 10*rem/d is a single decimal digit
      scaled = ({4'd0, rem} * 68'd10) / {4'd0, q.denominator};
      ans.digit = scaled[3:0];
      ans.ok = 1'b1;
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [63:0] rand_bits(input int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  function automatic fraction_query_t make_query(input logic [63:0] n, input logic [63:0] d,
                                                 input logic [63:0] p);
    fraction_query_t q;
    q.numerator = n;
    q.denominator = d;
    q.position = p;
    return q;
  endfunction

  function automatic fraction_query_t random_proper(input bit full_width);
    logic [63:0] d;
    logic [63:0] p;
    d = rand_bits(full_width ? 64 : $urandom_range(1, 64));
    if (d == 0) d = 64'd1;
    p = full_width ? rand_bits(64) : rand_bits($urandom_range(1, 12));
    if (p == 0) p = 64'd1;
    return make_query(rand_bits(64) % d, d, p);
  endfunction

  function automatic fraction_query_t random_reject();
    reject_kind_t    kind;
    fraction_query_t q;
    logic [63:0]     a;
    logic [63:0]     b;
    kind = reject_kind_t'($urandom_range(0, 2));
    q = random_proper(1'b0);
    case (kind)
      REJ_ZERO_DEN: begin
        q.denominator = '0;
        q.numerator = rand_bits($urandom_range(1, 64));
      end
      REJ_BIG_NUM: begin
        a = rand_bits($urandom_range(1, 64));
        b = rand_bits($urandom_range(1, 64));
        q.numerator = (a > b) ? a : b;
        q.denominator = (a > b) ? b : a;
      end
      default: begin
        q.position = '0;
      end
    endcase
    return q;
  endfunction

  initial begin : stimulus
    int big_left;
    big_left = 6;

    // rejected operand sets
    queries_to_send.push_back(make_query(64'd0, 64'd0, 64'd1));
    queries_to_send.push_back(make_query(64'd5, 64'd5, 64'd1));
    queries_to_send.push_back(make_query(64'd7, 64'd3, 64'd1));
    queries_to_send.push_back(make_query(64'd1, 64'd3, 64'd0));
    queries_to_send.push_back(make_query(ALL_ONES, 64'd0, ALL_ONES));
    queries_to_send.push_back(make_query(64'd1, 64'd1, 64'd1));
    queries_to_send.push_back(make_query(ALL_ONES, ALL_ONES, 64'd2));
    // denominator of one
    queries_to_send.push_back(make_query(64'd0, 64'd1, 64'd1));
    queries_to_send.push_back(make_query(64'd0, 64'd1, 64'd77));
    // small fractions
    queries_to_send.push_back(make_query(64'd1, 64'd2, 64'd1));
    queries_to_send.push_back(make_query(64'd1, 64'd7, 64'd1));
    queries_to_send.push_back(make_query(64'd1, 64'd7, 64'd2));
    queries_to_send.push_back(make_query(64'd3, 64'd7, 64'd6));
    queries_to_send.push_back(make_query(64'd1, 64'd10, 64'd1));
    queries_to_send.push_back(make_query(64'd1, 64'd10, 64'd2));
    queries_to_send.push_back(make_query(64'd1, 64'd3, ALL_ONES));
    queries_to_send.push_back(make_query(64'd123456789, 64'd1000000007, 64'd1000));
    // extremes of the datapath
    queries_to_send.push_back(make_query(ALL_ONES - 64'd1, ALL_ONES, 64'd1));
    queries_to_send.push_back(make_query(64'd0, ALL_ONES, 64'd5));
    queries_to_send.push_back(make_query(64'h8000_0000_0000_0000, ALL_ONES, 64'd3));
    queries_to_send.push_back(make_query(ALL_ONES - 64'd1, ALL_ONES, ALL_ONES));
    queries_to_send.push_back(make_query(64'd1, 64'h8000_0000_0000_0001, 64'd40));
    long_positions = 2;

    repeat (78) begin
      if ($urandom_range(0, 99) < 12) begin
        queries_to_send.push_back(random_reject());
      end else if (big_left > 0 && $urandom_range(0, 99) < 7) begin
        queries_to_send.push_back(random_proper(1'b1));
        big_left--;
        long_positions++;
      end else begin
        queries_to_send.push_back(random_proper(1'b0));
      end
    end

    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (queries_to_send.size() != 0 || in_valid || digits_due.size() != 0);
    // let any stray result show up
    repeat (100) @(negedge clk);

    $display("covered %0d digit results: %0d accepted and %0d rejected operand sets",
             digits_seen, accepted_sets, rejected_sets);
    $display("%0d queries used full-width positions", long_positions);
    if (errors == 0 && digits_due.size() == 0) begin
      $display("PASS fraction_decimal_digit");
    end else begin
      $display("FAIL fraction_decimal_digit");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : driver
    fraction_query_t q;
    int              burst_left;
    int              gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 8);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        q = make_query(in_numerator, in_denominator, in_position);
        digits_due.push_back(predict_digit(q));
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queries_to_send.size() != 0) begin
          q = queries_to_send.pop_front();
          in_numerator <= q.numerator;
          in_denominator <= q.denominator;
          in_position <= q.position;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin : receiver
    int          hold_left;
    bit          hold_done;
    logic [15:0] pattern_ctr;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      pattern_ctr = '0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && digits_seen == 2) begin
      // long hold-off so the quick rejects behind pile up and stall the input
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      pattern_ctr++;
      case (pattern_ctr[8:7])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ready <= (pattern_ctr[1:0] == 2'd0);
        default: out_ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor
    digit_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      digits_seen <= digits_seen + 1;
      if (out_valid_res) accepted_sets <= accepted_sets + 1;
      else rejected_sets <= rejected_sets + 1;
      if (digits_due.size() == 0) begin
        $error("result transfer with nothing expected: digit %0d valid_res %0b",
               out_digit, out_valid_res);
        errors++;
      end else begin
        want = digits_due.pop_front();
        if (out_digit !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, out_digit);
          errors++;
        end
        if (out_valid_res !== want.ok) begin
          $error("valid_res: expected %0b, got %0b", want.ok, out_valid_res);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", idle_cycles);
        $display("FAIL fraction_decimal_digit");
        $finish;
      end
    end
  end

endmodule
